### rtl/core/lgc_pkg.sv
// ----------------------------------------------------------------------------
// lgc_pkg: shared types and constants for label gap compaction
// Bitmap geometry, op codes and the bitmap update struct.
// ----------------------------------------------------------------------------
package lgc_pkg;

	// label and bitmap geometry
	localparam int LABEL_W    = 8;
	localparam int NUM_LABELS = 2 ** LABEL_W;
	localparam int IDX_W      = 4;
	localparam int GROUP_W    = 2 ** IDX_W;
	localparam int GRP_SEL_W  = LABEL_W - IDX_W;
	localparam int NUM_GROUPS = NUM_LABELS / GROUP_W;
	localparam int GCNT_W     = IDX_W + 1;
	localparam int TOTAL_W    = LABEL_W + 1;

	// item op codes
	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_RECORD = 2'd1,
		OP_XLATE  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// presence bitmap, grouped, and per-group counts
	typedef logic [NUM_GROUPS-1:0][GROUP_W-1:0] map_t;
	typedef logic [NUM_GROUPS-1:0][GCNT_W-1:0]  gcnt_t;

	// bitmap update request
	typedef struct packed {
		logic               clr;
		logic               set;
		logic [LABEL_W-1:0] label;
	} upd_t;

endpackage

### rtl/core/label_gap_compaction.sv
// A translate beat passes through the input register, then the result register.
// Throughput: one item per cycle; the input stage stalls only while a translate
// result waits in the output register and out_ready is low.
// Clear and record beats give no result; their bitmap update is seen by the
// next item. Reset clears the presence bitmap, its counters and all valids.
// ----------------------------------------------------------------------------
// label_gap_compaction: top level of the label compaction block
// Input register, presence bitmap with counts, rank logic and a result
// register with valid/ready on both sides.
// ----------------------------------------------------------------------------
module label_gap_compaction (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  op,
	input  logic [lgc_pkg::LABEL_W-1:0] label,
	input  logic                        defined,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [lgc_pkg::LABEL_W-1:0] new_label,
	output logic                        present,
	output logic                        is_defined,
	output logic [lgc_pkg::TOTAL_W-1:0] cluster_count
);

	logic                        valid_s1;
	logic [1:0]                  op_s1;
	logic [lgc_pkg::LABEL_W-1:0] label_s1;
	logic                        defined_s1;

	logic                        out_valid_q;
	logic [lgc_pkg::LABEL_W-1:0] new_label_q;
	logic                        present_q;
	logic                        is_defined_q;
	logic [lgc_pkg::TOTAL_W-1:0] count_q;

	lgc_pkg::upd_t               upd;
	lgc_pkg::map_t               map;
	lgc_pkg::gcnt_t              gcnt;
	logic [lgc_pkg::TOTAL_W-1:0] total;
	logic [lgc_pkg::LABEL_W-1:0] below;
	logic                        here;

	logic is_xlate;
	logic out_free;
	logic adv;
	logic load_out;

	// stage handshake
	assign is_xlate = (op_s1 == lgc_pkg::OP_XLATE);
	assign out_free = !out_valid_q || out_ready;
	assign adv      = valid_s1 && (!is_xlate || out_free);
	assign load_out = adv && is_xlate;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			op_s1      <= op;
			label_s1   <= label;
			defined_s1 <= defined;
		end
	end

	// bitmap update as the beat leaves the input stage
	assign upd.clr   = adv && (op_s1 == lgc_pkg::OP_CLEAR);
	assign upd.set   = adv && (op_s1 == lgc_pkg::OP_RECORD) && defined_s1;
	assign upd.label = label_s1;

	lgc_bitmap u_bitmap (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (upd),
		.map    (map),
		.gcnt   (gcnt),
		.total  (total)
	);

	lgc_rank u_rank (
		.map   (map),
		.gcnt  (gcnt),
		.label (label_s1),
		.below (below),
		.here  (here)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			count_q      <= total;
			is_defined_q <= defined_s1;
			if (defined_s1) begin
				new_label_q <= below;
				present_q   <= here;
			end else begin
				new_label_q <= label_s1;
				present_q   <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign new_label     = new_label_q;
	assign present       = present_q;
	assign is_defined    = is_defined_q;
	assign cluster_count = count_q;

endmodule

### rtl/core/lgc_bitmap.sv
// ----------------------------------------------------------------------------
// lgc_bitmap: presence bitmap with running counts
// Holds one bit per label plus a count per group of labels and the total
// count, all kept up to date as labels are recorded or the map is cleared.
// ----------------------------------------------------------------------------
module lgc_bitmap (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lgc_pkg::upd_t               upd,
	output lgc_pkg::map_t               map,
	output lgc_pkg::gcnt_t              gcnt,
	output logic [lgc_pkg::TOTAL_W-1:0] total
);

	lgc_pkg::map_t               map_q;
	lgc_pkg::gcnt_t              gcnt_q;
	logic [lgc_pkg::TOTAL_W-1:0] total_q;

	logic [lgc_pkg::GRP_SEL_W-1:0] grp;
	logic [lgc_pkg::IDX_W-1:0]     idx;
	logic                          is_new;

	// decode the label and spot a first-time record
	assign grp    = upd.label[lgc_pkg::LABEL_W-1:lgc_pkg::IDX_W];
	assign idx    = upd.label[lgc_pkg::IDX_W-1:0];
	assign is_new = upd.set && !map_q[grp][idx];

	// bitmap and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q   <= '0;
			gcnt_q  <= '0;
			total_q <= '0;
		end else if (upd.clr) begin
			map_q   <= '0;
			gcnt_q  <= '0;
			total_q <= '0;
		end else if (is_new) begin
			map_q[grp][idx] <= 1'b1;
			gcnt_q[grp]     <= gcnt_q[grp] + lgc_pkg::GCNT_W'(1);
			total_q         <= total_q + lgc_pkg::TOTAL_W'(1);
		end
	end

	assign map   = map_q;
	assign gcnt  = gcnt_q;
	assign total = total_q;

endmodule

### rtl/core/lgc_rank.sv
// ----------------------------------------------------------------------------
// lgc_rank: rank of a label in the presence bitmap
// Counts the present labels below a given label from the group counts of
// the lower groups and a masked count inside the label's own group.
// ----------------------------------------------------------------------------
module lgc_rank (
	input  lgc_pkg::map_t               map,
	input  lgc_pkg::gcnt_t              gcnt,
	input  logic [lgc_pkg::LABEL_W-1:0] label,
	output logic [lgc_pkg::LABEL_W-1:0] below,
	output logic                        here
);

	localparam int L1_N = lgc_pkg::NUM_GROUPS / 2;
	localparam int L2_N = L1_N / 2;
	localparam int L3_N = L2_N / 2;

	logic [lgc_pkg::GRP_SEL_W-1:0] grp;
	logic [lgc_pkg::IDX_W-1:0]     idx;
	logic [lgc_pkg::GROUP_W-1:0]   row;
	logic [lgc_pkg::GROUP_W-1:0]   mask;
	logic [lgc_pkg::IDX_W:0]       inner;

	logic [lgc_pkg::NUM_GROUPS-1:0][lgc_pkg::GCNT_W-1:0] lo;
	logic [L1_N-1:0][lgc_pkg::GCNT_W:0]   l1;
	logic [L2_N-1:0][lgc_pkg::GCNT_W+1:0] l2;
	logic [L3_N-1:0][lgc_pkg::GCNT_W+2:0] l3;
	logic [lgc_pkg::GCNT_W+3:0]           outer;

	assign grp = label[lgc_pkg::LABEL_W-1:lgc_pkg::IDX_W];
	assign idx = label[lgc_pkg::IDX_W-1:0];
	assign row = map[grp];

	// keep only the counts of groups below the label's group
	always_comb begin
		for (int g = 0; g < lgc_pkg::NUM_GROUPS; g++) begin
			lo[g] = (lgc_pkg::GRP_SEL_W'(g) < grp) ? gcnt[g] : '0;
		end
	end

	// adder tree over the group counts
	always_comb begin
		for (int i = 0; i < L1_N; i++) begin
			l1[i] = {1'b0, lo[2*i]} + {1'b0, lo[2*i+1]};
		end
		for (int i = 0; i < L2_N; i++) begin
			l2[i] = {1'b0, l1[2*i]} + {1'b0, l1[2*i+1]};
		end
		for (int i = 0; i < L3_N; i++) begin
			l3[i] = {1'b0, l2[2*i]} + {1'b0, l2[2*i+1]};
		end
		outer = {1'b0, l3[0]} + {1'b0, l3[1]};
	end

	// present labels below the label inside its own group
	assign mask  = (lgc_pkg::GROUP_W'(1) << idx) - lgc_pkg::GROUP_W'(1);
	assign inner = (lgc_pkg::IDX_W+1)'($countones(row & mask));

	assign below = lgc_pkg::LABEL_W'(outer) + lgc_pkg::LABEL_W'(inner);
	assign here  = row[idx];

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: label gap compaction check
// Drives clear, record and translate beats through the valid/ready input and
// compares every translate result with a typed value or one reckoned from a
// presence bitmap kept on this side. A directed table comes first, then a full
// sweep, then random label sets under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;
	import lgc_pkg::*;

	// one translate result
	typedef struct packed {
		logic [LABEL_W-1:0] new_label;
		logic               present;
		logic               is_defined;
		logic [TOTAL_W-1:0] cluster_count;
	} rank_t;

	// one directed beat, with the result typed in where it is obvious
	typedef struct {
		op_t                code;
		logic [LABEL_W-1:0] lbl;
		logic               def;
		bit                 typed;
		rank_t              want;
	} row_t;

	localparam int CYCLE_LIMIT = 300000;

	logic                clk           = 1'b0;
	logic                arst_n        = 1'b0;
	logic                in_valid      = 1'b0;
	logic                in_ready;
	logic [1:0]          op            = OP_NONE;
	logic [LABEL_W-1:0]  label         = '0;
	logic                defined       = 1'b0;
	logic                out_valid;
	logic                out_ready     = 1'b0;
	logic [LABEL_W-1:0]  new_label;
	logic                present;
	logic                is_defined;
	logic [TOTAL_W-1:0]  cluster_count;

	// labels recorded since the last clear, and the results still owed
	logic [NUM_LABELS-1:0] seen_labels = '0;
	rank_t                 pending_ranks [$];

	int errors     = 0;
	int cycles     = 0;
	int send_idle  = 0;
	int recv_stall = 0;

	label_gap_compaction DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.op            (op),
		.label         (label),
		.defined       (defined),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.new_label     (new_label),
		.present       (present),
		.is_defined    (is_defined),
		.cluster_count (cluster_count)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** label_gap_compaction: FAILED **");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// compacted label of one translate beat against the current bitmap
	function automatic rank_t rank_of(logic [LABEL_W-1:0] lbl, logic def);
		rank_t r;
		int    below;
		below = 0;
		for (int i = 0; i < NUM_LABELS; i++)
			if (i < lbl && seen_labels[i])
				below++;
		r.cluster_count = TOTAL_W'($countones(seen_labels));
		r.is_defined    = def;
		if (def) begin
			r.new_label = LABEL_W'(below);
			r.present   = seen_labels[lbl];
		end else begin
			// undefined labels pass straight through
			r.new_label = lbl;
			r.present   = 1'b0;
		end
		return r;
	endfunction

	// result check, sampled mid-cycle so the edge order does not matter
	always @(negedge clk) begin
		rank_t want;
		rank_t got;
		if (arst_n && out_valid && out_ready) begin
			got = {new_label, present, is_defined, cluster_count};
			if (pending_ranks.size() == 0) begin
				$display("%0t: result with none expected: new_label=%0d present=%0b",
					$time, got.new_label, got.present);
				errors++;
			end else begin
				want = pending_ranks.pop_front();
				if (got !== want) begin
					$display("%0t: expected new_label=%0d present=%0b is_defined=%0b count=%0d",
						$time, want.new_label, want.present, want.is_defined,
						want.cluster_count);
					$display("%0t: actual   new_label=%0d present=%0b is_defined=%0b count=%0d",
						$time, got.new_label, got.present, got.is_defined,
						got.cluster_count);
					errors++;
				end
			end
		end
	end

	// drive one beat, hold it until accepted, and update the bitmap copy or queue the expected result
	task automatic send_beat(op_t code, logic [LABEL_W-1:0] lbl, logic def, bit typed,
			rank_t want);
		if ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		in_valid <= 1'b1;
		op       <= code;
		label    <= lbl;
		defined  <= def;
		do @(negedge clk); while (!in_ready);
		case (code)
			OP_CLEAR:  seen_labels = '0;
			OP_RECORD: if (def) seen_labels[lbl] = 1'b1;
			OP_XLATE:  pending_ranks.push_back(typed ? want : rank_of(lbl, def));
			default:   ;
		endcase
		@(posedge clk);
	endtask

	// random label sets: clear in most rounds, record a clustered set, translate labels from it or anywhere
	task automatic run_phase(int s_idle, int r_stall, int quota);
		int                 done;
		int                 base;
		int                 span;
		int                 roll;
		logic [LABEL_W-1:0] l;
		send_idle  = s_idle;
		recv_stall = r_stall;
		done       = 0;
		while (done < quota) begin
			if ($urandom_range(9) < 8) begin
				send_beat(OP_CLEAR, LABEL_W'($urandom_range(255)), 1'($urandom_range(1)),
					1'b0, '0);
				done++;
			end
			base = $urandom_range(255);
			span = (1 << $urandom_range(8)) - 1;
			repeat ($urandom_range(1, 24)) begin
				l    = LABEL_W'(base + $urandom_range(span));
				roll = $urandom_range(19);
				if (roll == 0)
					send_beat(OP_NONE, LABEL_W'($urandom_range(255)),
						1'($urandom_range(1)), 1'b0, '0);
				else if (roll == 1)
					send_beat(OP_RECORD, l, 1'b0, 1'b0, '0);
				else begin
					send_beat(OP_RECORD, l, 1'b1, 1'b0, '0);
					done++;
				end
			end
			repeat ($urandom_range(1, 12)) begin
				if ($urandom_range(1))
					l = LABEL_W'(base + $urandom_range(span));
				else
					l = LABEL_W'($urandom_range(255));
				send_beat(OP_XLATE, l, ($urandom_range(6) != 0), 1'b0, '0);
				done++;
			end
		end
	endtask

	// main sequence
	initial begin
		row_t plan [23];
		plan = '{
			'{OP_XLATE,  8'd0,   1'b1, 1'b1, '{8'd0,   1'b0, 1'b1, 9'd0}},
			'{OP_XLATE,  8'd255, 1'b1, 1'b1, '{8'd0,   1'b0, 1'b1, 9'd0}},
			'{OP_XLATE,  8'd255, 1'b0, 1'b1, '{8'd255, 1'b0, 1'b0, 9'd0}},
			'{OP_XLATE,  8'd0,   1'b0, 1'b1, '{8'd0,   1'b0, 1'b0, 9'd0}},
			'{OP_RECORD, 8'd0,   1'b1, 1'b0, '0},
			'{OP_RECORD, 8'd255, 1'b1, 1'b0, '0},
			// undefined record and the unused op leave the bitmap alone
			'{OP_RECORD, 8'd7,   1'b0, 1'b0, '0},
			'{OP_NONE,   8'd9,   1'b1, 1'b0, '0},
			'{OP_XLATE,  8'd0,   1'b1, 1'b1, '{8'd0,   1'b1, 1'b1, 9'd2}},
			'{OP_XLATE,  8'd255, 1'b1, 1'b1, '{8'd1,   1'b1, 1'b1, 9'd2}},
			'{OP_XLATE,  8'd7,   1'b1, 1'b1, '{8'd1,   1'b0, 1'b1, 9'd2}},
			'{OP_XLATE,  8'd9,   1'b1, 1'b1, '{8'd1,   1'b0, 1'b1, 9'd2}},
			'{OP_XLATE,  8'd170, 1'b0, 1'b1, '{8'd170, 1'b0, 1'b0, 9'd2}},
			// recording twice counts once
			'{OP_RECORD, 8'd255, 1'b1, 1'b0, '0},
			'{OP_XLATE,  8'd255, 1'b1, 1'b1, '{8'd1,   1'b1, 1'b1, 9'd2}},
			'{OP_CLEAR,  8'd0,   1'b0, 1'b0, '0},
			'{OP_XLATE,  8'd255, 1'b1, 1'b1, '{8'd0,   1'b0, 1'b1, 9'd0}},
			'{OP_RECORD, 8'd85,  1'b1, 1'b0, '0},
			'{OP_RECORD, 8'd170, 1'b1, 1'b0, '0},
			'{OP_XLATE,  8'd128, 1'b1, 1'b0, '0},
			'{OP_XLATE,  8'd170, 1'b1, 1'b0, '0},
			'{OP_CLEAR,  8'd255, 1'b1, 1'b0, '0},
			'{OP_XLATE,  8'd85,  1'b1, 1'b1, '{8'd0,   1'b0, 1'b1, 9'd0}}
		};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (plan[i])
			send_beat(plan[i].code, plan[i].lbl, plan[i].def, plan[i].typed, plan[i].want);

		// every label present: full count and top rank
		for (int i = 0; i < NUM_LABELS; i++)
			send_beat(OP_RECORD, LABEL_W'(i), 1'b1, 1'b0, '0);
		send_beat(OP_XLATE, 8'd255, 1'b1, 1'b1, '{8'd255, 1'b1, 1'b1, 9'd256});
		send_beat(OP_XLATE, 8'd0,   1'b1, 1'b1, '{8'd0,   1'b1, 1'b1, 9'd256});
		send_beat(OP_XLATE, 8'd128, 1'b0, 1'b1, '{8'd128, 1'b0, 1'b0, 9'd256});

		// random sets under each idle mix
		run_phase(0,  0,  32);
		run_phase(68, 0,  32);
		run_phase(0,  68, 32);
		run_phase(20, 20, 32);

		in_valid <= 1'b0;
		while (pending_ranks.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("** label_gap_compaction: PASSED **");
		else
			$display("** label_gap_compaction: FAILED **");
		$finish;
	end

endmodule

### filelist.f
rtl/core/lgc_pkg.sv
rtl/core/lgc_bitmap.sv
rtl/core/lgc_rank.sv
rtl/core/label_gap_compaction.sv
bench/testbench.sv
